/* rtl/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the 1-Wire bus master: transaction
// payloads, configuration set, command codes and the CRC-8 fold.
// ----------------------------------------------------------------------------
package owbm_pkg;

   // command codes carried in the action field
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_SAMPLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_REC   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_LEN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_LOW   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_LOW    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_SAMPLE = 3'd6;

   // Dallas/Maxim CRC-8, reflected form
   localparam logic [7:0] CRC_POLY = 8'h8C;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] write_byte;
      logic       bus_level;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       device_present;
      logic [7:0] read_data;
      logic [7:0] crc_value;
   } rsp_type;

   typedef struct packed {
      logic [8:0] reset_low_time;
      logic [7:0] presence_sample_time;
      logic [8:0] reset_recovery_time;
      logic [7:0] slot_length;
      logic [7:0] short_low_time;
      logic [7:0] long_low_time;
      logic [7:0] read_sample_time;
   } cfg_type;

   // fold one byte into the running CRC, LSB first
   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

endpackage

/* rtl/owbm_csr.sv */
// ----------------------------------------------------------------------------
// owbm_csr
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [owbm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output owbm_pkg::cfg_type                  cfg
);

   owbm_pkg::cfg_type cfg_ff, cfg_in;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            owbm_pkg::CSR_RESET_LOW:   cfg_in.reset_low_time       = csr_wdata;
            owbm_pkg::CSR_PRES_SAMPLE: cfg_in.presence_sample_time = csr_wdata[7:0];
            owbm_pkg::CSR_RESET_REC:   cfg_in.reset_recovery_time  = csr_wdata;
            owbm_pkg::CSR_SLOT_LEN:    cfg_in.slot_length          = csr_wdata[7:0];
            owbm_pkg::CSR_SHORT_LOW:   cfg_in.short_low_time       = csr_wdata[7:0];
            owbm_pkg::CSR_LONG_LOW:    cfg_in.long_low_time        = csr_wdata[7:0];
            owbm_pkg::CSR_READ_SAMPLE: cfg_in.read_sample_time     = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time       <= 9'd480;
         cfg_ff.presence_sample_time <= 8'd70;
         cfg_ff.reset_recovery_time  <= 9'd410;
         cfg_ff.slot_length          <= 8'd70;
         cfg_ff.short_low_time       <= 8'd6;
         cfg_ff.long_low_time        <= 8'd60;
         cfg_ff.read_sample_time     <= 8'd15;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/owbm_engine.sv */
// ----------------------------------------------------------------------------
// owbm_engine
// Bus sequencer state and its one-tick update: reset pulse, presence
// sample, recovery, write and read slots, read assembly and CRC.
// ----------------------------------------------------------------------------
module owbm_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  owbm_pkg::req_type  item,
   input  owbm_pkg::cfg_type  cfg,
   output owbm_pkg::rsp_type  result
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_RLOW  = 3'd1;
   localparam logic [2:0] PH_RWAIT = 3'd2;
   localparam logic [2:0] PH_RREC  = 3'd3;
   localparam logic [2:0] PH_WRITE = 3'd4;
   localparam logic [2:0] PH_READ  = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic [9:0] tick_ff, tick_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] rdata_ff, rdata_in;
   logic [7:0] crc_ff, crc_in;
   logic       pres_ff, pres_in;

   // state after a possible command start
   logic [2:0]  ph_e;
   logic [9:0]  tick_e;
   logic [2:0]  bit_e;
   logic [7:0]  shift_e;
   logic [7:0]  crc_e;
   logic [10:0] tick_p1;
   logic        last;
   logic [7:0]  low_time;
   logic        drive;
   logic        done;
   logic        sample;

   always_comb begin
      // command start, only from idle
      ph_e    = phase_ff;
      tick_e  = tick_ff;
      bit_e   = bit_ff;
      shift_e = shift_ff;
      crc_e   = crc_ff;
      if (phase_ff == PH_IDLE && item.action != owbm_pkg::ACT_TICK) begin
         tick_e = 10'd0;
         bit_e  = 3'd0;
         unique case (item.action)
            owbm_pkg::ACT_RESET: begin
               ph_e  = PH_RLOW;
               crc_e = 8'd0;
            end
            owbm_pkg::ACT_WRITE: begin
               ph_e    = PH_WRITE;
               shift_e = item.write_byte;
            end
            default: begin
               ph_e    = PH_READ;
               shift_e = 8'd0;
            end
         endcase
      end

      tick_p1  = {1'b0, tick_e} + 11'd1;
      last     = tick_p1 >= {3'd0, cfg.slot_length};
      low_time = shift_e[bit_e] ? cfg.short_low_time : cfg.long_low_time;
      sample   = (tick_e == {2'd0, cfg.read_sample_time}) ||
                 (last && ({2'd0, cfg.read_sample_time} > tick_e));

      phase_in = ph_e;
      tick_in  = tick_e;
      bit_in   = bit_e;
      shift_in = shift_e;
      rdata_in = rdata_ff;
      crc_in   = crc_e;
      pres_in  = pres_ff;
      drive    = 1'b0;
      done     = 1'b0;

      // one tick of the active phase
      unique case (ph_e)
         PH_RLOW: begin
            drive = 1'b1;
            if (tick_p1 >= {2'd0, cfg.reset_low_time}) begin
               phase_in = PH_RWAIT;
               tick_in  = 10'd0;
            end else begin
               tick_in = tick_p1[9:0];
            end
         end
         PH_RWAIT: begin
            if (tick_p1 >= {3'd0, cfg.presence_sample_time}) begin
               pres_in  = ~item.bus_level;
               phase_in = PH_RREC;
               tick_in  = 10'd0;
            end else begin
               tick_in = tick_p1[9:0];
            end
         end
         PH_RREC: begin
            if (tick_p1 >= {2'd0, cfg.reset_recovery_time}) begin
               phase_in = PH_IDLE;
               tick_in  = 10'd0;
               done     = 1'b1;
            end else begin
               tick_in = tick_p1[9:0];
            end
         end
         PH_WRITE, PH_READ: begin
            if (ph_e == PH_WRITE) begin
               drive = tick_e < {2'd0, low_time};
            end else begin
               drive = tick_e < {2'd0, cfg.short_low_time};
               if (sample) begin
                  shift_in[bit_e] = shift_e[bit_e] | item.bus_level;
               end
            end
            if (last) begin
               tick_in = 10'd0;
               if (bit_e == 3'd7) begin
                  if (ph_e == PH_READ) begin
                     rdata_in = shift_in;
                     crc_in   = owbm_pkg::crc_fold(crc_e, shift_in);
                  end
                  bit_in   = 3'd0;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  bit_in = bit_e + 3'd1;
               end
            end else begin
               tick_in = tick_p1[9:0];
            end
         end
         PH_IDLE: ;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 10'd0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         rdata_ff <= 8'd0;
         crc_ff   <= 8'd0;
         pres_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         rdata_ff <= rdata_in;
         crc_ff   <= crc_in;
         pres_ff  <= pres_in;
      end
   end

   // result of this tick
   assign result.drive_low      = drive;
   assign result.busy_res       = phase_in != PH_IDLE;
   assign result.done_res       = done;
   assign result.device_present = pres_in;
   assign result.read_data      = rdata_in;
   assign result.crc_value      = crc_in;

endmodule

/* rtl/onewire_bus_master.sv */
// ----------------------------------------------------------------------------
// onewire_bus_master
// 1-Wire bus master with reset/presence, byte write, byte read and a
// running CRC-8 over read bytes.
//
// Usage: send one transaction on req_ per bus tick (typically 1 us). Each
// carries a command (tick only, reset, write byte, read byte), the byte to
// write and the sampled line level. A command is taken only while idle;
// one that arrives during a running command is ignored. Every request
// yields exactly one response on rsp_ with the line drive for that tick,
// busy/done flags, the presence result, the last byte read and the CRC.
// The request lands in an input register, the sequencer updates in one pass
// and the response lands in an output register. Throughput is one transaction
// per cycle while rsp_stall is low; the sequencer state is a single register
// set that advances once per tick. A stalled response holds the output
// register; the input register still refills while it is empty, after which
// req_stall follows rsp_stall. Reset (synchronous) empties both registers,
// puts the sequencer in idle with cleared data and CRC, and loads the default
// timings. Timing registers must be written on csr_ only while no command is
// running; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module onewire_bus_master (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  owbm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output owbm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [owbm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   owbm_pkg::cfg_type cfg;
   owbm_pkg::req_type in_data_ff;
   owbm_pkg::rsp_type rsp_data_ff;
   owbm_pkg::rsp_type result;
   logic              in_valid_ff, in_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   logic              req_take;

   owbm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   owbm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // pipeline handshake
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
